[rtl/core/ssla_pkg.sv]
package ssla_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int SHORT_W  = 16;
    localparam int LONG_W   = 19;

    // largest short value, bounds the running sum
    localparam int SHORT_MAX = 40950;

    // divide by three as multiply by ceil(2^17 / 3) and shift by 17,
    // exact for every dividend below 2^17
    localparam int          SCALED_W    = 17;
    localparam int          RECIP_SHIFT = 17;
    localparam int          RECIP_W     = 16;
    localparam logic [15:0] RECIP3      = 16'd43691;

    localparam int WINDOW_DEPTH_DEF = 256;

    typedef struct packed {
        logic [SAMPLE_W-1:0] uv_sample_0;
        logic [SAMPLE_W-1:0] uv_sample_1;
        logic [SAMPLE_W-1:0] uv_sample_2;
        logic [SAMPLE_W-1:0] ir_sample_0;
        logic [SAMPLE_W-1:0] ir_sample_1;
        logic [SAMPLE_W-1:0] ir_sample_2;
    } t_in_item;

    typedef struct packed {
        logic [SHORT_W-1:0] uv_short;
        logic [SHORT_W-1:0] ir_short;
        logic [LONG_W-1:0]  uv_long;
        logic [LONG_W-1:0]  ir_long;
    } t_out_item;

endpackage

[rtl/core/smoke_short_long_average_core.sv]
// channel  | direction | handshake                        | payload
// ---------+-----------+----------------------------------+------------------------
// input    | in        | i_in_valid / o_in_ready          | i_in_item  (t_in_item)
// output   | out       | o_out_valid / i_out_ready        | o_out_item (t_out_item)
//
// one item at a time: accept, short value, history update, divider load,
// DIV_W restoring steps (DIV_W = sum width + 4, 28 at a depth of 256),
// output load; a new item is accepted only after the result of the last one
// has left the serial divider by the fill count and is in the output register
// i_rst_n is synchronous, active low; it clears control, position, fill and
// running sums, the history memory is not cleared and needs no pass
// the result waits in an output register, so a stalled output only holds
// the block when a second result is ready to go out
module smoke_short_long_average_core #(
    parameter int WINDOW_DEPTH = ssla_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ssla_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ssla_pkg::t_out_item  o_out_item
);

    localparam int SW     = ssla_pkg::SHORT_W;
    localparam int PW     = $clog2(WINDOW_DEPTH);
    localparam int CW     = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = $clog2(WINDOW_DEPTH * ssla_pkg::SHORT_MAX + 1);
    localparam int DIV_W  = SUM_W + 4;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam int PROD_W = ssla_pkg::SCALED_W + ssla_pkg::RECIP_W;

    localparam logic [PW-1:0]    POS_LAST  = PW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0]    FILL_FULL = CW'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] CNT_TOP   = CNT_W'(DIV_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHORT,
        S_UPDATE,
        S_LOAD,
        S_DIVIDE,
        S_DONE
    } t_state;

    t_state r_state;

    // latched input item
    ssla_pkg::t_in_item r_in;

    // short values of the item in flight
    logic [SW-1:0] r_uv_short;
    logic [SW-1:0] r_ir_short;

    // ring state
    logic [PW-1:0]    r_pos;
    logic [CW-1:0]    r_fill;
    logic [SUM_W-1:0] r_uv_sum;
    logic [SUM_W-1:0] r_ir_sum;

    // history memory, uv in the upper half of each word
    logic [2*SW-1:0] r_hist [WINDOW_DEPTH];
    logic [2*SW-1:0] r_rd_data;

    // serial divider, both channels share the divisor
    logic [DIV_W-1:0] r_uv_quo;
    logic [DIV_W-1:0] r_ir_quo;
    logic [CW-1:0]    r_uv_rem;
    logic [CW-1:0]    r_ir_rem;
    logic [CNT_W-1:0] r_cnt;

    // output register
    logic                r_out_valid;
    ssla_pkg::t_out_item r_out_item;

    // short value: (a + b + c) * 10 / 3
    function automatic logic [SW-1:0] short_of(
        input logic [ssla_pkg::SAMPLE_W-1:0] a,
        input logic [ssla_pkg::SAMPLE_W-1:0] b,
        input logic [ssla_pkg::SAMPLE_W-1:0] c
    );
        logic [ssla_pkg::SCALED_W-1:0] s;
        logic [ssla_pkg::SCALED_W-1:0] x10;
        logic [PROD_W-1:0]             prod;
        s    = ssla_pkg::SCALED_W'(a) + ssla_pkg::SCALED_W'(b) + ssla_pkg::SCALED_W'(c);
        x10  = (s << 3) + (s << 1);
        prod = PROD_W'(x10) * PROD_W'(ssla_pkg::RECIP3);
        return prod[ssla_pkg::RECIP_SHIFT +: SW];
    endfunction

    // one restoring step: remainder and quotient bit
    function automatic logic [CW:0] div_step(
        input logic [CW-1:0] rem,
        input logic          bit_in,
        input logic [CW-1:0] divisor
    );
        logic [CW:0] trial;
        logic [CW:0] diff;
        trial = {rem, bit_in};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            return {1'b1, diff[CW-1:0]};
        end else begin
            return {1'b0, trial[CW-1:0]};
        end
    endfunction

    logic             in_accept;
    logic             ring_full;
    logic [SUM_W-1:0] n_uv_sum;
    logic [SUM_W-1:0] n_ir_sum;
    logic [PW-1:0]    n_pos;
    logic [CW:0]      uv_step;
    logic [CW:0]      ir_step;
    logic             out_free;

    assign in_accept = i_in_valid && o_in_ready;
    assign ring_full = (r_fill == FILL_FULL);
    assign out_free  = !r_out_valid || i_out_ready;

    // running sums: add the new value, drop the overwritten one once full
    always_comb begin
        if (ring_full) begin
            n_uv_sum = r_uv_sum - SUM_W'(r_rd_data[2*SW-1:SW]) + SUM_W'(r_uv_short);
            n_ir_sum = r_ir_sum - SUM_W'(r_rd_data[SW-1:0]) + SUM_W'(r_ir_short);
        end else begin
            n_uv_sum = r_uv_sum + SUM_W'(r_uv_short);
            n_ir_sum = r_ir_sum + SUM_W'(r_ir_short);
        end
        n_pos = (r_pos == POS_LAST) ? '0 : r_pos + PW'(1);
    end

    assign uv_step = div_step(r_uv_rem, r_uv_quo[DIV_W-1], r_fill);
    assign ir_step = div_step(r_ir_rem, r_ir_quo[DIV_W-1], r_fill);

    // history memory: read every cycle at the write position, read data registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_hist[r_pos];
        if (r_state == S_UPDATE) begin
            r_hist[r_pos] <= {r_uv_short, r_ir_short};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_fill      <= '0;
            r_uv_sum    <= '0;
            r_ir_sum    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_DONE the output register is reloaded below instead
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_in    <= i_in_item;
                        r_state <= S_SHORT;
                    end
                end
                // the memory read of the old entry happens in this cycle
                S_SHORT: begin
                    r_uv_short <= short_of(r_in.uv_sample_0, r_in.uv_sample_1,
                                           r_in.uv_sample_2);
                    r_ir_short <= short_of(r_in.ir_sample_0, r_in.ir_sample_1,
                                           r_in.ir_sample_2);
                    r_state    <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_uv_sum <= n_uv_sum;
                    r_ir_sum <= n_ir_sum;
                    r_pos    <= n_pos;
                    if (!ring_full) begin
                        r_fill <= r_fill + CW'(1);
                    end
                    r_state <= S_LOAD;
                end
                // dividend is sum times ten
                S_LOAD: begin
                    r_uv_quo <= (DIV_W'(r_uv_sum) << 3) + (DIV_W'(r_uv_sum) << 1);
                    r_ir_quo <= (DIV_W'(r_ir_sum) << 3) + (DIV_W'(r_ir_sum) << 1);
                    r_uv_rem <= '0;
                    r_ir_rem <= '0;
                    r_cnt    <= CNT_TOP;
                    r_state  <= S_DIVIDE;
                end
                S_DIVIDE: begin
                    r_uv_rem <= uv_step[CW-1:0];
                    r_ir_rem <= ir_step[CW-1:0];
                    r_uv_quo <= {r_uv_quo[DIV_W-2:0], uv_step[CW]};
                    r_ir_quo <= {r_ir_quo[DIV_W-2:0], ir_step[CW]};
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_item.uv_short <= r_uv_short;
                        r_out_item.ir_short <= r_ir_short;
                        r_out_item.uv_long  <= r_uv_quo[ssla_pkg::LONG_W-1:0];
                        r_out_item.ir_long  <= r_ir_quo[ssla_pkg::LONG_W-1:0];
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count above window depth");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("write position outside the ring");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVIDE) |-> (r_fill != '0) && (r_uv_rem < r_fill)
                                  && (r_ir_rem < r_fill))
        else $error("divider remainder not below divisor");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("item accepted while another is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && !i_out_ready
            |=> (r_state == S_DONE) && $stable(r_out_item))
        else $error("pending result overwritten");
`endif

endmodule
